// ===== rtl/jdsm_pkg.sv =====
`timescale 1ns / 1ps
package jdsm_pkg;

  localparam int RAW_W     = 10;
  localparam int DROP_BITS = 2;
  localparam int CAL_W     = 8;
  localparam int DZ_W      = 7;
  localparam int ANGLE_W   = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 3'd3;

  localparam logic [CAL_W-1:0] CAL_MIN_RST   = 8'd0;
  localparam logic [CAL_W-1:0] CAL_MID_RST   = 8'd128;
  localparam logic [CAL_W-1:0] CAL_MAX_RST   = 8'd255;
  localparam logic [DZ_W-1:0]  DEAD_BAND_RST = 7'd4;

  localparam int ANGLE_FULL = 100;

  // Divider: 16-bit dividend, 8-bit divisor, two quotient bits per cycle
  localparam int DVD_W     = 16;
  localparam int DVS_W     = 8;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/jdsm_div.sv =====
`timescale 1ns / 1ps
module jdsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  jdsm_pkg::div_req_t req,
  output jdsm_pkg::div_rsp_t rsp
);

  logic [jdsm_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [jdsm_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [jdsm_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [jdsm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  logic [jdsm_pkg::DVS_W:0] t1, r1, t2, r2;
  logic                     ge1, ge2;

  // Two restoring steps per cycle: dividend bits shift out the top,
  // quotient bits shift in at the bottom.
  always_comb begin
    t1  = {rem_r, quo_r[jdsm_pkg::DVD_W-1]};
    ge1 = (t1 >= {1'b0, dvs_r});
    r1  = ge1 ? (t1 - {1'b0, dvs_r}) : t1;
    t2  = {r1[jdsm_pkg::DVS_W-1:0], quo_r[jdsm_pkg::DVD_W-2]};
    ge2 = (t2 >= {1'b0, dvs_r});
    r2  = ge2 ? (t2 - {1'b0, dvs_r}) : t2;
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = r2[jdsm_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[jdsm_pkg::DVD_W-3:0], ge1, ge2};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == jdsm_pkg::DIV_CNT_W'(jdsm_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/jdsm_hist.sv =====
`timescale 1ns / 1ps
module jdsm_hist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic signed [jdsm_pkg::ANGLE_W-1:0] angle,
  output logic signed [jdsm_pkg::ANGLE_W-1:0] med
);

  logic signed [jdsm_pkg::ANGLE_W-1:0] prev0_r, prev0_nxt;
  logic signed [jdsm_pkg::ANGLE_W-1:0] prev1_r, prev1_nxt;
  logic signed [jdsm_pkg::ANGLE_W-1:0] lo_a, hi_a, lo_b;

  // median = max(min(a, p0), min(max(a, p0), p1))
  always_comb begin
    lo_a = (angle < prev0_r) ? angle : prev0_r;
    hi_a = (angle > prev0_r) ? angle : prev0_r;
    lo_b = (hi_a < prev1_r) ? hi_a : prev1_r;
    med  = (lo_a > lo_b) ? lo_a : lo_b;
  end

  always_comb begin
    prev0_nxt = prev0_r;
    prev1_nxt = prev1_r;
    if (push) begin
      prev1_nxt = prev0_r;
      prev0_nxt = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev0_r <= '0;
      prev1_r <= '0;
    end else begin
      prev0_r <= prev0_nxt;
      prev1_r <= prev1_nxt;
    end
  end

endmodule

// ===== rtl/joystick_deadzone_scale_median3_unit.sv =====
`timescale 1ns / 1ps
// Joystick axis conditioner: converter sample in, percent deflection out.
// Input stream: in_tdata[9:0] is the 10-bit converter reading; one beat per
// sample. The two low bits are dropped, the value is clamped to the
// calibrated range, centered, cut by the dead band and scaled to +-100.
// Output stream: one beat per input beat, filtered angle (median of three)
// in the low byte and the unfiltered angle in the high byte.
// Configuration: cfg_wr_en with cfg_index 0..3 writes cal_min, cal_mid,
// cal_max and dead_band; other indexes are ignored. Write only when idle.
// Path from the accepting edge to out_tvalid: setup, the divider steps,
// the divider flag, the result register. The divider is radix-4 serial;
// a new sample is taken only in idle, once the previous result has been
// emitted to the output register.
// The next sample is accepted while a result still waits in the output
// register; a stalled receiver holds that result, and the block then
// waits in its last step before overwriting it.
// Reset: calibration returns to 0 / 128 / 255 / 4, the two-sample history
// clears to zero and both streams go empty.
module joystick_deadzone_scale_median3_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [jdsm_pkg::IN_TDATA_W-1:0]      in_tdata,   // [9:0] raw_sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [jdsm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] filtered_angle,
                                                           // [15:8] scaled_angle
  input  logic                                 cfg_wr_en,
  input  logic [jdsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jdsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [jdsm_pkg::CAL_W-1:0] cal_min_r, cal_min_nxt;
  logic [jdsm_pkg::CAL_W-1:0] cal_mid_r, cal_mid_nxt;
  logic [jdsm_pkg::CAL_W-1:0] cal_max_r, cal_max_nxt;
  logic [jdsm_pkg::DZ_W-1:0]  dead_r, dead_nxt;

  logic [jdsm_pkg::CAL_W-1:0] samp_r, samp_nxt;
  logic                       neg_r, neg_nxt;
  logic                       zero_r, zero_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [jdsm_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;

  logic [jdsm_pkg::CAL_W-1:0] v_in, v_clamp;
  logic signed [9:0]          d, dz, dv;
  logic                       below, above;
  logic [jdsm_pkg::CAL_W-1:0] mag, dvs_mag;
  logic [jdsm_pkg::DVD_W-1:0] prod;

  logic [6:0]                          q_sat;
  logic signed [jdsm_pkg::ANGLE_W-1:0] angle, med;
  logic                                accept, emit;

  jdsm_pkg::div_req_t div_req;
  jdsm_pkg::div_rsp_t div_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Clamp: the test against cal_min wins when calibration is inverted
  always_comb begin
    v_in = in_tdata[jdsm_pkg::RAW_W-1:jdsm_pkg::DROP_BITS];
    if (v_in < cal_min_r)      v_clamp = cal_min_r;
    else if (v_in > cal_max_r) v_clamp = cal_max_r;
    else                       v_clamp = v_in;
  end

  // Center, dead band, side span, and the magnitude times 100
  always_comb begin
    d     = $signed({2'b00, samp_r}) - $signed({2'b00, cal_mid_r});
    dz    = $signed({3'b000, dead_r});
    below = (d < -dz);
    above = (d > dz);
    if (below) begin
      mag = 8'(-(d + dz));
      dv  = $signed({2'b00, cal_mid_r}) - $signed({2'b00, cal_min_r});
    end else begin
      mag = 8'(d - dz);
      dv  = $signed({2'b00, cal_max_r}) - $signed({2'b00, cal_mid_r});
    end
    dvs_mag = dv[9] ? 8'(-dv) : 8'(dv);
    prod    = ({8'd0, mag} << 6) + ({8'd0, mag} << 5) + ({8'd0, mag} << 2);
  end

  assign div_req.start    = (state_r == S_PREP);
  assign div_req.dividend = prod;
  assign div_req.divisor  = dvs_mag;

  jdsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Saturate the magnitude, then apply the sign or force a zero angle
  always_comb begin
    if (div_rsp.quotient > jdsm_pkg::DVD_W'(jdsm_pkg::ANGLE_FULL))
      q_sat = 7'(jdsm_pkg::ANGLE_FULL);
    else
      q_sat = div_rsp.quotient[6:0];
    if (zero_r)     angle = '0;
    else if (neg_r) angle = -$signed({1'b0, q_sat});
    else            angle = $signed({1'b0, q_sat});
  end

  jdsm_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (emit),
    .angle (angle),
    .med   (med)
  );

  always_comb begin
    state_nxt     = state_r;
    samp_nxt      = samp_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          samp_nxt  = v_clamp;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        neg_nxt   = below ^ dv[9];
        zero_nxt  = !(below || above) || (dv == 10'sd0);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold here until the output register is free
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {angle, med};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cal_min_nxt = cal_min_r;
    cal_mid_nxt = cal_mid_r;
    cal_max_nxt = cal_max_r;
    dead_nxt    = dead_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        jdsm_pkg::CFG_CAL_MIN:   cal_min_nxt = cfg_wdata;
        jdsm_pkg::CFG_CAL_MID:   cal_mid_nxt = cfg_wdata;
        jdsm_pkg::CFG_CAL_MAX:   cal_max_nxt = cfg_wdata;
        jdsm_pkg::CFG_DEAD_BAND: dead_nxt    = cfg_wdata[jdsm_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cal_min_r   <= jdsm_pkg::CAL_MIN_RST;
      cal_mid_r   <= jdsm_pkg::CAL_MID_RST;
      cal_max_r   <= jdsm_pkg::CAL_MAX_RST;
      dead_r      <= jdsm_pkg::DEAD_BAND_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cal_min_r   <= cal_min_nxt;
      cal_mid_r   <= cal_mid_nxt;
      cal_max_r   <= cal_max_nxt;
      dead_r      <= dead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_PREP))
    else $error("accepted beat did not start setup");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_data_r[15:8]) <= 8'sd100 &&
                     $signed(out_data_r[15:8]) >= -8'sd100))
    else $error("scaled angle out of range");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result was not registered");

endmodule
